/* src/oaht_pkg.sv */
`default_nettype none
package oaht_pkg;

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic [3:0]  MAX_KEY_BYTES = 4'd8;
    localparam logic [31:0] HASH_SEED     = 32'd5381;
    localparam logic [3:0]  CAP_LOG2_RESET = 4'd10;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] key_word;
        logic [3:0]  key_length;
        logic [31:0] value_in;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value_out;
        logic [9:0]  slot_index;
        logic [10:0] entry_count;
        logic [10:0] removed_count;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       hash_step;
        logic       probe_init;
        logic       probe_next;
        logic       wr_ins;
        logic       wr_del;
        logic       occ_clear;
        logic       sweep_step;
        logic       set_res;
        logic [2:0] res_status;
        logic       out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req_type;
        logic       len_zero;
        logic       full;
        logic       hash_done;
        logic       sweep_done;
        logic       empty;
        logic       match;
        logic       home_again;
        logic       bound_hit;
        logic       out_free;
    } sts_t;

endpackage
`default_nettype wire

/* src/oaht_datapath.sv */
`default_nettype none
module oaht_datapath
    import oaht_pkg::*;
#(
    parameter int TABLE_LOG2 = 10,
    parameter int VALUE_BITS = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire req_t       req_in,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_data,
    input  wire cmd_t       cmd,
    output sts_t            sts,
    output logic            out_valid,
    input  wire logic       out_ready,
    output res_t            out_data
);

    localparam int AW    = TABLE_LOG2;
    localparam int SLOTS = 1 << AW;
    localparam int VB    = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
    localparam int CW    = AW + 1;
    localparam int PW    = AW + 2;

    // Storage.
    logic          occ_mem [SLOTS];
    logic [63:0]   key_mem [SLOTS];
    logic [VB-1:0] val_mem [SLOTS];

    logic [1:0]    req_type_reg;
    logic [63:0]   key_reg;
    logic [3:0]    len_reg;
    logic [VB-1:0] val_reg;
    logic [63:0]   kshift_reg;
    logic [3:0]    hcnt_reg;
    logic [31:0]   hash_reg;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] home_reg;
    logic [PW-1:0] p_reg;
    logic [AW-1:0] sweep_reg;
    logic [CW-1:0] occ_reg;
    logic [3:0]    cap_log2_reg;
    logic          out_valid_reg;
    res_t          res_reg;
    res_t          out_reg;
    logic          occ_rd_reg;
    logic [63:0]   key_rd_reg;
    logic [VB-1:0] val_rd_reg;

    logic [3:0]    len_sat;
    logic [63:0]   key_masked;
    logic [4:0]    cl;
    logic [CW-1:0] cap;
    logic [AW-1:0] mask;
    logic [PW-1:0] bound;
    logic [PW-1:0] p_plus1;
    logic [7:0]    hbyte;
    logic [31:0]   hash_next;
    logic [CW-1:0] occ_next;
    logic [31:0]   vout;
    res_t          res_next;

    // Key length saturation and byte masking of the incoming request.
    always_comb
    begin
        len_sat = (req_in.key_length > MAX_KEY_BYTES) ? MAX_KEY_BYTES : req_in.key_length;
        for (int i = 0; i < 8; i++)
        begin
            key_masked[8*i +: 8] = (4'(i) < len_sat) ? req_in.key_word[8*i +: 8] : 8'h00;
        end
    end

    // Active capacity and probe bound.
    always_comb
    begin
        cl      = ({1'b0, cap_log2_reg} > 5'(AW)) ? 5'(AW) : {1'b0, cap_log2_reg};
        cap     = CW'(1) << cl;
        mask    = AW'(cap - CW'(1));
        bound   = (req_type_reg == REQ_INSERT) ? {1'b0, cap} : {cap, 1'b0};
        p_plus1 = p_reg + PW'(1);
        hbyte   = kshift_reg[7:0];
        hash_next = (hash_reg << 5) + hash_reg + {{24{hbyte[7]}}, hbyte};
    end

    // Status towards the controller.
    always_comb
    begin
        sts.req_type   = req_type_reg;
        sts.len_zero   = (len_reg == 4'd0);
        sts.full       = ({1'b0, occ_reg} >= {1'b0, cap});
        sts.hash_done  = (hcnt_reg == len_reg);
        sts.sweep_done = (sweep_reg == {AW{1'b1}});
        sts.empty      = !occ_rd_reg;
        sts.match      = (key_rd_reg == key_reg);
        sts.home_again = (p_reg != '0) && (idx_reg == home_reg);
        sts.bound_hit  = (p_plus1 >= bound);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // Entry count after this cycle's update, and the result being formed.
    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.occ_clear)
        begin
            occ_next = '0;
        end
        else if (cmd.wr_ins)
        begin
            occ_next = occ_reg + CW'(1);
        end
        else if (cmd.wr_del && occ_reg != '0)
        begin
            occ_next = occ_reg - CW'(1);
        end

        vout = 32'd0;
        if (cmd.res_status == ST_OK && req_type_reg == REQ_INSERT)
        begin
            vout = 32'(val_reg);
        end
        else if (cmd.res_status == ST_DUP
                 || (cmd.res_status == ST_OK && req_type_reg == REQ_LOOKUP))
        begin
            vout = 32'(val_rd_reg);
        end

        res_next.status      = cmd.res_status;
        res_next.value_out   = vout;
        res_next.slot_index  = (cmd.res_status == ST_OK || cmd.res_status == ST_DUP)
                               && req_type_reg != REQ_CLEAR ? 10'(idx_reg) : 10'd0;
        res_next.entry_count = 11'(occ_next);
        if (req_type_reg == REQ_CLEAR)
        begin
            res_next.removed_count = 11'(occ_reg);
        end
        else if (cmd.wr_del)
        begin
            res_next.removed_count = 11'd1;
        end
        else
        begin
            res_next.removed_count = 11'd0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            cap_log2_reg  <= CAP_LOG2_RESET;
            out_valid_reg <= 1'b0;
            sweep_reg     <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (cfg_we)
            begin
                cap_log2_reg <= cfg_data;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.sweep_step)
            begin
                sweep_reg <= sweep_reg + AW'(1);
            end
        end
    end

    // Request, hash and probe registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= req_in.req_type;
            key_reg      <= key_masked;
            len_reg      <= len_sat;
            val_reg      <= VB'(req_in.value_in);
            kshift_reg   <= key_masked;
            hcnt_reg     <= 4'd0;
            hash_reg     <= HASH_SEED;
        end
        else if (cmd.hash_step)
        begin
            kshift_reg <= kshift_reg >> 8;
            hcnt_reg   <= hcnt_reg + 4'd1;
            hash_reg   <= hash_next;
        end
        if (cmd.probe_init)
        begin
            idx_reg  <= hash_reg[AW-1:0] & mask;
            home_reg <= hash_reg[AW-1:0] & mask;
            p_reg    <= '0;
        end
        else if (cmd.probe_next)
        begin
            idx_reg <= (idx_reg + AW'(p_plus1)) & mask;
            p_reg   <= p_plus1;
        end
        if (cmd.set_res)
        begin
            res_reg <= res_next;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // Slot memories: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_step)
        begin
            occ_mem[sweep_reg] <= 1'b0;
        end
        else if (cmd.wr_ins)
        begin
            occ_mem[idx_reg] <= 1'b1;
        end
        else if (cmd.wr_del)
        begin
            occ_mem[idx_reg] <= 1'b0;
        end
        if (cmd.wr_ins)
        begin
            key_mem[idx_reg] <= key_reg;
            val_mem[idx_reg] <= val_reg;
        end
        occ_rd_reg <= occ_mem[idx_reg];
        key_rd_reg <= key_mem[idx_reg];
        val_rd_reg <= val_mem[idx_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

/* src/oaht_ctrl.sv */
`default_nettype none
module oaht_ctrl
    import oaht_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_HASH   = 7'b0000100,
        S_READ   = 7'b0001000,
        S_CHECK  = 7'b0010000,
        S_CLEAR  = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Sequencing of hash, probes, clearing and result hand-off.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (sts.req_type == REQ_CLEAR)
                begin
                    cmd.occ_clear  = 1'b1;
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_CLEAR;
                end
                else if (!sts.hash_done)
                begin
                    cmd.hash_step = 1'b1;
                end
                else if (sts.req_type == REQ_INSERT && sts.full)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_FULL;
                    state_next     = S_RESULT;
                end
                else if (sts.len_zero)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_EMPTY;
                    state_next     = S_RESULT;
                end
                else
                begin
                    cmd.probe_init = 1'b1;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_RESULT;
                cmd.set_res = 1'b1;
                if (sts.req_type == REQ_INSERT)
                begin
                    if (sts.empty)
                    begin
                        cmd.wr_ins     = 1'b1;
                        cmd.res_status = ST_OK;
                    end
                    else if (sts.match)
                    begin
                        cmd.res_status = ST_DUP;
                    end
                    else if (sts.bound_hit)
                    begin
                        cmd.res_status = ST_FULL;
                    end
                    else
                    begin
                        cmd.set_res    = 1'b0;
                        cmd.probe_next = 1'b1;
                        state_next     = S_READ;
                    end
                end
                else
                begin
                    if (sts.home_again || sts.empty)
                    begin
                        cmd.res_status = ST_NOTFOUND;
                    end
                    else if (sts.match)
                    begin
                        cmd.res_status = ST_OK;
                        cmd.wr_del     = (sts.req_type == REQ_DELETE);
                    end
                    else if (sts.bound_hit)
                    begin
                        cmd.res_status = ST_NOTFOUND;
                    end
                    else
                    begin
                        cmd.set_res    = 1'b0;
                        cmd.probe_next = 1'b1;
                        state_next     = S_READ;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/open_addressing_hash_table.sv */
`default_nettype none
// Open-addressed key/value table with a djb2 home slot and triangular probing over
// the active capacity of up to 2**TABLE_LOG2 slots held in on-chip memory. One
// request is handled at a time and yields one result; the result sits in an output
// register, so the next request is taken while it waits. A request is taken, its
// key is hashed byte by byte in the hash unit (up to eight bytes) and the probe is
// started; each probed slot is a registered memory read followed by a compare, and
// then the result is handed over. Clear walks every built slot, one per cycle.
// After reset the same pass runs over every slot before the first request is
// accepted; configuration writes are taken at any time.
module open_addressing_hash_table
    import oaht_pkg::*;
#(
    parameter int TABLE_LOG2 = 10,
    parameter int VALUE_BITS = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire req_t       in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output res_t            out_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [3:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // The capacity register can be written in any cycle.
    assign cfg_ready = 1'b1;

    oaht_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    oaht_datapath #(
        .TABLE_LOG2 (TABLE_LOG2),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_in    (in_data),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

/* verif/open_addressing_hash_table_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module open_addressing_hash_table_tb;
    import oaht_pkg::*;

    localparam int TBL_LOG2 = 10;
    localparam int SLOTS    = 1 << TBL_LOG2;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready;
    res_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [3:0] cfg_data;

    open_addressing_hash_table #(.TABLE_LOG2(TBL_LOG2), .VALUE_BITS(32)) i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the table contents.
    logic [63:0] shadow_key [SLOTS];
    logic [3:0]  shadow_len [SLOTS];
    logic [31:0] shadow_val [SLOTS];
    int unsigned shadow_occ;
    logic [3:0]  shadow_cap_log2;

    req_t request_queue [$];
    res_t result_queue [$];
    int   error_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off_cycles;
    logic cfg_pending;
    logic [3:0] cfg_pending_data;

    // Keys are drawn from a small pool so that inserts, hits and deletes collide.
    logic [63:0] key_pool [16];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] djb2_hash(logic [63:0] kw, int unsigned len);
        logic [31:0] h;
        logic [31:0] sb;
        h = HASH_SEED;
        for (int i = 0; i < len; i++)
        begin
            sb = {{24{kw[8*i+7]}}, kw[8*i +: 8]};
            h = (h << 5) + h + sb;
        end
        return h;
    endfunction

    // Works out the result of one request and updates the shadow table.
    function automatic res_t predict_table_result(req_t rq);
        res_t        r;
        int unsigned len;
        logic [63:0] kw;
        int unsigned cl;
        int unsigned cap;
        logic [31:0] msk;
        logic [31:0] base;
        logic [31:0] idx;
        logic [31:0] home;
        int unsigned removed;
        logic        found;
        logic [31:0] hit;
        r = '0;
        removed = 0;
        found = 1'b0;
        hit = 0;
        len = (rq.key_length > 8) ? 8 : rq.key_length;
        kw = rq.key_word;
        if (len < 8)
            kw = kw & ((64'd1 << (8 * len)) - 64'd1);
        cl = (shadow_cap_log2 > TBL_LOG2) ? TBL_LOG2 : shadow_cap_log2;
        cap = 1 << cl;
        msk = cap - 1;
        base = djb2_hash(kw, len);
        r.status = ST_OK;
        if (rq.req_type == REQ_CLEAR)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (shadow_len[i] != 4'd0)
                    removed++;
                shadow_len[i] = 4'd0;
            end
            shadow_occ = 0;
        end
        else if (rq.req_type == REQ_INSERT)
        begin
            if (shadow_occ >= cap)
                r.status = ST_FULL;
            else if (len == 0)
                r.status = ST_EMPTY;
            else
            begin
                r.status = ST_FULL;
                for (int unsigned p = 0; p < cap; p++)
                begin
                    idx = (base + 32'((p * (p + 1)) >> 1)) & msk;
                    if (shadow_len[idx] == 4'd0)
                    begin
                        shadow_key[idx] = kw;
                        shadow_val[idx] = rq.value_in;
                        shadow_len[idx] = 4'(len);
                        shadow_occ++;
                        r.status = ST_OK;
                        r.slot_index = idx[9:0];
                        r.value_out = rq.value_in;
                        break;
                    end
                    if (shadow_key[idx] == kw)
                    begin
                        r.status = ST_DUP;
                        r.slot_index = idx[9:0];
                        r.value_out = shadow_val[idx];
                        break;
                    end
                end
            end
        end
        else if (len == 0)
            r.status = ST_EMPTY;
        else
        begin
            home = base & msk;
            for (int unsigned p = 0; p < 2 * cap; p++)
            begin
                idx = (base + 32'((p * (p + 1)) >> 1)) & msk;
                if (p != 0 && idx == home)
                    break;
                if (shadow_len[idx] == 4'd0)
                    break;
                if (shadow_key[idx] == kw)
                begin
                    found = 1'b1;
                    hit = idx;
                    break;
                end
            end
            if (!found)
                r.status = ST_NOTFOUND;
            else
            begin
                r.slot_index = hit[9:0];
                if (rq.req_type == REQ_LOOKUP)
                    r.value_out = shadow_val[hit];
                else
                begin
                    shadow_len[hit] = 4'd0;
                    if (shadow_occ > 0)
                        shadow_occ--;
                    removed = 1;
                end
            end
        end
        r.entry_count = 11'(shadow_occ);
        r.removed_count = 11'(removed);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Driver: offers queued requests and queues the predicted result of each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                result_queue.push_back(predict_table_result(in_data));
                void'(request_queue.pop_front());
            end
            if (!(in_valid && !in_ready))
            begin
                if (request_queue.size() > ((in_valid && in_ready) ? 0 : 0) &&
                    !(in_valid && !in_ready) && $urandom_range(99) >= send_idle_pct &&
                    !(in_valid && in_ready && request_queue.size() == 0))
                begin
                    in_valid <= 1'b1;
                    in_data <= request_queue[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Register write channel.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_data <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            shadow_cap_log2 = cfg_data;
            cfg_valid <= 1'b0;
            cfg_pending = 1'b0;
        end
        else if (cfg_pending && !cfg_valid)
        begin
            cfg_valid <= 1'b1;
            cfg_data <= cfg_pending_data;
        end
    end

    // Monitor: receiver stalls and result checks.
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (result_queue.size() == 0)
                begin
                    report_mismatch("unexpected result", 64'(out_data.status), 64'd0);
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (out_data.status !== want.status)
                        report_mismatch("status", 64'(out_data.status),
                                        64'(want.status));
                    if (out_data.value_out !== want.value_out)
                        report_mismatch("value_out", 64'(out_data.value_out),
                                        64'(want.value_out));
                    if (out_data.slot_index !== want.slot_index)
                        report_mismatch("slot_index", 64'(out_data.slot_index),
                                        64'(want.slot_index));
                    if (out_data.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 64'(out_data.entry_count),
                                        64'(want.entry_count));
                    if (out_data.removed_count !== want.removed_count)
                        report_mismatch("removed_count", 64'(out_data.removed_count),
                                        64'(want.removed_count));
                end
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic req_t make_request(logic [1:0] kind, logic [63:0] kw,
                                          logic [3:0] len, logic [31:0] val);
        req_t rq;
        rq.req_type = kind;
        rq.key_word = kw;
        rq.key_length = len;
        rq.value_in = val;
        return rq;
    endfunction

    // Waits until every queued request has been taken and answered.
    task automatic wait_drained();
        while (request_queue.size() != 0 || in_valid || result_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_capacity(logic [3:0] v);
        cfg_pending_data = v;
        cfg_pending = 1'b1;
        while (cfg_pending)
            @(posedge clk);
    endtask

    // Random request, mostly from the key pool with a valid length.
    function automatic req_t random_request();
        logic [1:0]  kind;
        logic [63:0] kw;
        logic [3:0]  len;
        int          sel;
        sel = $urandom_range(99);
        if (sel < 45)
            kind = REQ_INSERT;
        else if (sel < 75)
            kind = REQ_LOOKUP;
        else if (sel < 99)
            kind = REQ_DELETE;
        else
            kind = REQ_CLEAR;
        if ($urandom_range(9) < 8)
        begin
            kw = key_pool[$urandom_range(15)];
            len = 4'($urandom_range(8, 1));
            if ($urandom_range(3) == 0)
                kw = {$urandom, $urandom};
        end
        else
        begin
            kw = {$urandom, $urandom};
            len = 4'($urandom_range(15));
        end
        return make_request(kind, kw, len, $urandom);
    endfunction

    task automatic run_random(int n, logic [3:0] cap);
        write_capacity(cap);
        for (int i = 0; i < n; i++)
            request_queue.push_back(random_request());
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        cfg_pending = 1'b0;
        cfg_pending_data = '0;
        shadow_occ = 0;
        shadow_cap_log2 = CAP_LOG2_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_len[i] = 4'd0;
            shadow_key[i] = '0;
            shadow_val[i] = '0;
        end
        for (int i = 0; i < 16; i++)
            key_pool[i] = {$urandom, $urandom};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every request kind and the special cases.
        request_queue.push_back(make_request(REQ_INSERT, '1, 4'd8, '1));
        request_queue.push_back(make_request(REQ_INSERT, '1, 4'd15, 32'd5));
        request_queue.push_back(make_request(REQ_LOOKUP, '1, 4'd9, '0));
        request_queue.push_back(make_request(REQ_INSERT, 64'h80, 4'd1, 32'd1));
        request_queue.push_back(make_request(REQ_LOOKUP, 64'hFFFF_FF80, 4'd1, '0));
        request_queue.push_back(make_request(REQ_INSERT, '0, 4'd0, 32'd7));
        request_queue.push_back(make_request(REQ_LOOKUP, '0, 4'd0, '0));
        request_queue.push_back(make_request(REQ_DELETE, '0, 4'd0, '0));
        request_queue.push_back(make_request(REQ_INSERT, 64'h0, 4'd3, 32'h55));
        request_queue.push_back(make_request(REQ_LOOKUP, 64'h0, 4'd2, '0));
        request_queue.push_back(make_request(REQ_DELETE, 64'h80, 4'd1, '0));
        request_queue.push_back(make_request(REQ_DELETE, 64'h80, 4'd1, '0));
        request_queue.push_back(make_request(REQ_LOOKUP, 64'h1234, 4'd2, '0));
        request_queue.push_back(make_request(REQ_CLEAR, '1, 4'd15, '1));
        request_queue.push_back(make_request(REQ_CLEAR, '0, 4'd0, '0));
        wait_drained();

        // Tiny tables: fill up, full status, wrap of the probe sequence.
        write_capacity(4'd0);
        request_queue.push_back(make_request(REQ_INSERT, 64'h11, 4'd1, 32'd1));
        request_queue.push_back(make_request(REQ_INSERT, 64'h22, 4'd1, 32'd2));
        request_queue.push_back(make_request(REQ_INSERT, '0, 4'd0, 32'd2));
        request_queue.push_back(make_request(REQ_LOOKUP, 64'h22, 4'd1, '0));
        wait_drained();
        write_capacity(4'd15);
        request_queue.push_back(make_request(REQ_LOOKUP, 64'h11, 4'd1, '0));
        wait_drained();

        // Random phases across settings and idling patterns.
        run_random(150, 4'd2);
        send_idle_pct = 66;
        run_random(150, 4'd10);
        send_idle_pct = 0;
        recv_stall_pct = 66;
        run_random(150, 4'd3);
        send_idle_pct = 8;
        recv_stall_pct = 8;
        run_random(150, 4'd1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random(150, 4'd4);

        // Long receiver hold-off while requests keep coming.
        hold_off_cycles = 400;
        run_random(100, 4'd12);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        run_random(150, 4'd5);
        send_idle_pct = 66;
        recv_stall_pct = 66;
        run_random(130, 4'd10);

        repeat (SLOTS + 100) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
src/oaht_pkg.sv
src/oaht_datapath.sv
src/oaht_ctrl.sv
src/open_addressing_hash_table.sv
verif/open_addressing_hash_table_tb.sv
